// ----- hw/rtl/wmme_pkg.sv -----
package wmme_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int MAX_BUCKETS = 65536;
	localparam int ADDR_W      = $clog2(MAX_BUCKETS);
	localparam int CNT_W       = $clog2(MAX_BUCKETS + 1);
	localparam int RATE_W      = 19;
	localparam int BPS_W       = 11;
	localparam int CFG_W       = 19;
	localparam int TIME_W      = 32;
	localparam int TIME_FRAC   = 12;
	localparam int FRAC_MASK   = (1 << TIME_FRAC) - 1;
	localparam int ACC_W       = 48;
	localparam int ACC_LIM_BIT = 46;
	localparam int MEM_W       = 2 * SAMPLE_W;
	localparam int PROD_W      = TIME_W + BPS_W + 1;
	localparam int IDX_W       = PROD_W + 1 - TIME_FRAC;

	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);
	localparam logic [BPS_W-1:0]  BPS_RESET  = BPS_W'(100);
	localparam logic [BPS_W-1:0]  BPS_MIN    = BPS_W'(1);
	localparam logic [BPS_W-1:0]  BPS_MAX    = BPS_W'(2000);

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	localparam logic REG_SAMPLE_RATE = 1'b0;
	localparam logic REG_BPS         = 1'b1;

	localparam logic REQ_PUSH  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [1:0] {
		BIN_IDLE,
		BIN_CHECK,
		BIN_LAST
	} bin_state_t;

	typedef enum logic [2:0] {
		QRY_IDLE,
		QRY_RANGE,
		QRY_CLAMP,
		QRY_SCAN,
		QRY_DONE
	} qry_state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [MEM_W-1:0]  data;
	} mem_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic             busy;
		logic [CNT_W-1:0] total;
		logic             ovf;
	} bin_status_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] low;
		logic signed [SAMPLE_W-1:0] high;
	} peak_t;

	function automatic logic [BPS_W-1:0] bps_clamp(input logic [BPS_W-1:0] b);
		logic [BPS_W-1:0] r;
		r = b;
		if (b < BPS_MIN) begin
			r = BPS_MIN;
		end else if (b > BPS_MAX) begin
			r = BPS_MAX;
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/wmme_ram.sv -----
module wmme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/wmme_binner.sv -----
module wmme_binner (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [wmme_pkg::SAMPLE_W-1:0]  sample_in,
	input  logic                                  last_in,
	input  logic [wmme_pkg::RATE_W-1:0]           rate,
	input  logic [wmme_pkg::BPS_W-1:0]            bps,
	output wmme_pkg::mem_wr_t                     wr,
	output wmme_pkg::bin_status_t                 status
);

	wmme_pkg::bin_state_t state_q, state_d;

	logic                                 open_q;
	logic [wmme_pkg::CNT_W-1:0]           total_q;
	logic [wmme_pkg::CNT_W-1:0]           cur_q;
	logic signed [wmme_pkg::SAMPLE_W-1:0] low_q;
	logic signed [wmme_pkg::SAMPLE_W-1:0] high_q;
	logic                                 has_q;
	logic [wmme_pkg::ACC_W-1:0]           sacc_q;
	logic [wmme_pkg::ACC_W-1:0]           bacc_q;
	logic                                 ovf_q;
	logic signed [wmme_pkg::SAMPLE_W-1:0] smp_q;
	logic                                 last_q;

	logic edge_hit;
	logic close;
	logic room;

	assign edge_hit = sacc_q > bacc_q;
	assign room     = cur_q < wmme_pkg::CNT_W'(wmme_pkg::MAX_BUCKETS);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wmme_pkg::BIN_IDLE: begin
				if (start) begin
					state_d = wmme_pkg::BIN_CHECK;
				end
			end
			wmme_pkg::BIN_CHECK: begin
				if (!edge_hit) begin
					state_d = last_q ? wmme_pkg::BIN_LAST : wmme_pkg::BIN_IDLE;
				end
			end
			wmme_pkg::BIN_LAST: begin
				state_d = wmme_pkg::BIN_IDLE;
			end
			default: begin
				state_d = wmme_pkg::BIN_IDLE;
			end
		endcase
	end

	always_comb begin
		close = ((state_q == wmme_pkg::BIN_CHECK) && edge_hit) ||
			(state_q == wmme_pkg::BIN_LAST);
		wr.en   = close && room;
		wr.addr = cur_q[wmme_pkg::ADDR_W-1:0];
		wr.data = has_q ? {low_q, high_q} : '0;
		status.busy  = state_q != wmme_pkg::BIN_IDLE;
		status.total = total_q;
		status.ovf   = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wmme_pkg::BIN_IDLE;
			open_q  <= 1'b0;
			total_q <= '0;
			cur_q   <= '0;
			low_q   <= wmme_pkg::SAMPLE_MAX;
			high_q  <= wmme_pkg::SAMPLE_MIN;
			has_q   <= 1'b0;
			sacc_q  <= '0;
			bacc_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == wmme_pkg::BIN_IDLE && start) begin
				if (!open_q) begin
					open_q  <= 1'b1;
					total_q <= '0;
					cur_q   <= '0;
					ovf_q   <= 1'b0;
					low_q   <= wmme_pkg::SAMPLE_MAX;
					high_q  <= wmme_pkg::SAMPLE_MIN;
					has_q   <= 1'b0;
					sacc_q  <= wmme_pkg::ACC_W'(bps);
					bacc_q  <= wmme_pkg::ACC_W'(rate);
				end else begin
					sacc_q <= sacc_q + wmme_pkg::ACC_W'(bps);
				end
			end
			if (state_q == wmme_pkg::BIN_CHECK && !edge_hit) begin
				if (sacc_q >= (wmme_pkg::ACC_W'(1) << wmme_pkg::ACC_LIM_BIT)) begin
					bacc_q <= bacc_q - sacc_q;
					sacc_q <= '0;
				end
				if (smp_q < low_q) begin
					low_q <= smp_q;
				end
				if (smp_q > high_q) begin
					high_q <= smp_q;
				end
				has_q <= 1'b1;
			end
			if (close) begin
				if (room) begin
					total_q <= cur_q + 1'b1;
					cur_q   <= cur_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
				low_q  <= wmme_pkg::SAMPLE_MAX;
				high_q <= wmme_pkg::SAMPLE_MIN;
				has_q  <= 1'b0;
				if (state_q == wmme_pkg::BIN_CHECK) begin
					bacc_q <= bacc_q + wmme_pkg::ACC_W'(rate);
				end else begin
					open_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wmme_pkg::BIN_IDLE && start) begin
			smp_q  <= sample_in;
			last_q <= last_in;
		end
	end

endmodule

// ----- hw/rtl/wmme_query.sv -----
module wmme_query (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [wmme_pkg::TIME_W-1:0]  from_in,
	input  logic signed [wmme_pkg::TIME_W-1:0]  to_in,
	input  logic [wmme_pkg::BPS_W-1:0]          bps,
	input  logic [wmme_pkg::CNT_W-1:0]          count,
	output wmme_pkg::mem_rd_t                   rd,
	input  logic [wmme_pkg::MEM_W-1:0]          rd_data,
	input  logic                                take,
	output logic                                res_valid,
	output wmme_pkg::peak_t                     res,
	output logic                                busy
);

	wmme_pkg::qry_state_t state_q, state_d;

	logic signed [wmme_pkg::PROD_W-1:0]   prod_from_s1;
	logic signed [wmme_pkg::PROD_W-1:0]   prod_to_s1;
	logic                                 empty_s1;
	logic [wmme_pkg::CNT_W-1:0]           count_q;
	logic signed [wmme_pkg::IDX_W-1:0]    first_s2;
	logic signed [wmme_pkg::IDX_W-1:0]    last_s2;
	logic [wmme_pkg::CNT_W-1:0]           idx_q;
	logic [wmme_pkg::CNT_W-1:0]           end_q;
	logic                                 rd_pend_s1;
	logic signed [wmme_pkg::SAMPLE_W-1:0] mn_q;
	logic signed [wmme_pkg::SAMPLE_W-1:0] mx_q;

	logic signed [wmme_pkg::PROD_W:0]     to_up;
	logic signed [wmme_pkg::IDX_W-1:0]    cnt_x;
	logic                                 zero;
	logic                                 issue;
	logic signed [wmme_pkg::SAMPLE_W-1:0] rd_low;
	logic signed [wmme_pkg::SAMPLE_W-1:0] rd_high;

	assign to_up   = (wmme_pkg::PROD_W+1)'(prod_to_s1) + (wmme_pkg::PROD_W+1)'(wmme_pkg::FRAC_MASK);
	assign cnt_x   = wmme_pkg::IDX_W'(count_q);
	assign zero    = empty_s1 || (last_s2 <= 0) || (first_s2 >= cnt_x);
	assign issue   = idx_q < end_q;
	assign rd_low  = rd_data[wmme_pkg::MEM_W-1:wmme_pkg::SAMPLE_W];
	assign rd_high = rd_data[wmme_pkg::SAMPLE_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wmme_pkg::QRY_IDLE: begin
				if (start) begin
					state_d = wmme_pkg::QRY_RANGE;
				end
			end
			wmme_pkg::QRY_RANGE: begin
				state_d = wmme_pkg::QRY_CLAMP;
			end
			wmme_pkg::QRY_CLAMP: begin
				state_d = zero ? wmme_pkg::QRY_DONE : wmme_pkg::QRY_SCAN;
			end
			wmme_pkg::QRY_SCAN: begin
				if (!issue) begin
					state_d = wmme_pkg::QRY_DONE;
				end
			end
			wmme_pkg::QRY_DONE: begin
				if (take) begin
					state_d = wmme_pkg::QRY_IDLE;
				end
			end
			default: begin
				state_d = wmme_pkg::QRY_IDLE;
			end
		endcase
	end

	always_comb begin
		rd.en     = (state_q == wmme_pkg::QRY_SCAN) && issue;
		rd.addr   = idx_q[wmme_pkg::ADDR_W-1:0];
		res_valid = state_q == wmme_pkg::QRY_DONE;
		res.low   = mn_q;
		res.high  = mx_q;
		busy      = state_q != wmme_pkg::QRY_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wmme_pkg::QRY_IDLE;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= rd.en;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wmme_pkg::QRY_IDLE && start) begin
			prod_from_s1 <= wmme_pkg::PROD_W'(from_in) * wmme_pkg::PROD_W'($signed({1'b0, bps}));
			prod_to_s1   <= wmme_pkg::PROD_W'(to_in) * wmme_pkg::PROD_W'($signed({1'b0, bps}));
			empty_s1     <= (count == '0) || !(to_in > from_in);
			count_q      <= count;
		end
		if (state_q == wmme_pkg::QRY_RANGE) begin
			first_s2 <= wmme_pkg::IDX_W'(prod_from_s1 >>> wmme_pkg::TIME_FRAC);
			last_s2  <= wmme_pkg::IDX_W'(to_up >>> wmme_pkg::TIME_FRAC);
		end
		if (state_q == wmme_pkg::QRY_CLAMP) begin
			idx_q <= (first_s2 < 0) ? '0 : wmme_pkg::CNT_W'(first_s2);
			end_q <= (last_s2 > cnt_x) ? count_q : wmme_pkg::CNT_W'(last_s2);
			mn_q  <= zero ? '0 : wmme_pkg::SAMPLE_MAX;
			mx_q  <= zero ? '0 : wmme_pkg::SAMPLE_MIN;
		end
		if (rd.en) begin
			idx_q <= idx_q + 1'b1;
		end
		if (rd_pend_s1) begin
			if (rd_low < mn_q) begin
				mn_q <= rd_low;
			end
			if (rd_high > mx_q) begin
				mx_q <= rd_high;
			end
		end
	end

endmodule

// ----- hw/rtl/waveform_minmax_envelope_top.sv -----
// Push beat: the binner stays busy while it closes buckets (one table write per cycle while the table has room);
// a push with last_sample also closes the open bucket. Pushes carry no result.
// Query beat: the range is computed and clamped, then the buckets in range are scanned, one
// table read per cycle; an empty range skips the scan. The result waits in the output register.
// Reset clears control state and loads 48000 and 100 into the rate registers.
// The bucket table is not cleared; only written entries are ever scanned.
module waveform_minmax_envelope_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic signed [wmme_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last_sample,
	input  logic signed [wmme_pkg::TIME_W-1:0]  from_time,
	input  logic signed [wmme_pkg::TIME_W-1:0]  to_time,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [wmme_pkg::SAMPLE_W-1:0] low_peak,
	output logic signed [wmme_pkg::SAMPLE_W-1:0] high_peak,
	output logic [wmme_pkg::CNT_W-1:0]          stored_buckets,
	output logic                                table_overflow,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [wmme_pkg::CFG_W-1:0]          cfg_data
);

	logic [wmme_pkg::RATE_W-1:0] rate_q;
	logic [wmme_pkg::BPS_W-1:0]  bps_q;
	logic [wmme_pkg::BPS_W-1:0]  bps_used;
	logic                        out_valid_q;

	logic                        accept;
	logic                        push_go;
	logic                        query_go;
	logic                        qry_busy;
	logic                        res_valid;
	logic                        take;
	logic [wmme_pkg::MEM_W-1:0]  rd_data;

	wmme_pkg::mem_wr_t     wr;
	wmme_pkg::mem_rd_t     rd;
	wmme_pkg::bin_status_t bin_st;
	wmme_pkg::peak_t       res;

	assign bps_used = wmme_pkg::bps_clamp(bps_q);
	assign in_stall = bin_st.busy | qry_busy;
	assign accept   = in_valid && !in_stall;
	assign push_go  = accept && (req_type == wmme_pkg::REQ_PUSH) && (rate_q != '0);
	assign query_go = accept && (req_type == wmme_pkg::REQ_QUERY);
	assign take     = res_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= wmme_pkg::RATE_RESET;
			bps_q  <= wmme_pkg::BPS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wmme_pkg::REG_SAMPLE_RATE: rate_q <= cfg_data[wmme_pkg::RATE_W-1:0];
				wmme_pkg::REG_BPS:         bps_q  <= cfg_data[wmme_pkg::BPS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			low_peak       <= res.low;
			high_peak      <= res.high;
			stored_buckets <= bin_st.total;
			table_overflow <= bin_st.ovf;
		end
	end

	wmme_binner u_binner (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (push_go),
		.sample_in (sample),
		.last_in   (last_sample),
		.rate      (rate_q),
		.bps       (bps_used),
		.wr        (wr),
		.status    (bin_st)
	);

	wmme_query u_query (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (query_go),
		.from_in   (from_time),
		.to_in     (to_time),
		.bps       (bps_used),
		.count     (bin_st.total),
		.rd        (rd),
		.rd_data   (rd_data),
		.take      (take),
		.res_valid (res_valid),
		.res       (res),
		.busy      (qry_busy)
	);

	wmme_ram #(
		.WIDTH (wmme_pkg::MEM_W),
		.DEPTH (wmme_pkg::MAX_BUCKETS)
	) u_table (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (rd_data)
	);

endmodule
